// ===== src/nfv5_pkg.sv =====
// ----------------------------------------------------------------------------
// nfv5_pkg
// Shared types, constants and field maps for the NetFlow v5 datagram parser.
// ----------------------------------------------------------------------------
`default_nettype none

package nfv5_pkg;

  localparam int unsigned MAX_RECORDS_DEFAULT = 30;
  localparam int unsigned HDR_BYTES           = 24;
  localparam int unsigned REC_BYTES           = 48;
  localparam int unsigned QUEUE_DEPTH         = 4;
  localparam logic [15:0] VERSION_RESET       = 16'd5;

  // header fields that carry checks
  localparam logic [4:0] HDR_FID_VERSION = 5'd0;
  localparam logic [4:0] HDR_FID_COUNT   = 5'd1;

  typedef enum logic [1:0] {
    KIND_HDR    = 2'd0,
    KIND_REC    = 2'd1,
    KIND_DONE   = 2'd2,
    KIND_REJECT = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ERR_NONE    = 2'd0,
    ERR_VERSION = 2'd1,
    ERR_COUNT   = 2'd2,
    ERR_TRUNC   = 2'd3
  } err_t;

  typedef struct packed {
    kind_t       kind;
    logic [4:0]  record_index;
    logic [4:0]  field_id;
    logic [31:0] field_value;
    err_t        error_code;
    logic        last_result;
  } result_t;

  // header byte position to field id
  function automatic logic [4:0] hdr_field(input logic [4:0] pos);
    logic [4:0] fid;
    case (pos)
      5'd0, 5'd1:                     fid = 5'd0;
      5'd2, 5'd3:                     fid = 5'd1;
      5'd4, 5'd5, 5'd6, 5'd7:         fid = 5'd2;
      5'd8, 5'd9, 5'd10, 5'd11:       fid = 5'd3;
      5'd12, 5'd13, 5'd14, 5'd15:     fid = 5'd4;
      5'd16, 5'd17, 5'd18, 5'd19:     fid = 5'd5;
      5'd20:                          fid = 5'd6;
      5'd21:                          fid = 5'd7;
      default:                        fid = 5'd8;
    endcase
    return fid;
  endfunction

  // true on the byte that completes a header field
  function automatic logic hdr_field_last(input logic [4:0] pos);
    logic last;
    case (pos)
      5'd1, 5'd3, 5'd7, 5'd11, 5'd15, 5'd19, 5'd20, 5'd21, 5'd23: last = 1'b1;
      default:                                                   last = 1'b0;
    endcase
    return last;
  endfunction

  // record byte offset to field id
  function automatic logic [4:0] rec_field(input logic [5:0] off);
    logic [4:0] fid;
    case (off)
      6'd0, 6'd1, 6'd2, 6'd3:         fid = 5'd0;
      6'd4, 6'd5, 6'd6, 6'd7:         fid = 5'd1;
      6'd8, 6'd9, 6'd10, 6'd11:       fid = 5'd2;
      6'd12, 6'd13:                   fid = 5'd3;
      6'd14, 6'd15:                   fid = 5'd4;
      6'd16, 6'd17, 6'd18, 6'd19:     fid = 5'd5;
      6'd20, 6'd21, 6'd22, 6'd23:     fid = 5'd6;
      6'd24, 6'd25, 6'd26, 6'd27:     fid = 5'd7;
      6'd28, 6'd29, 6'd30, 6'd31:     fid = 5'd8;
      6'd32, 6'd33:                   fid = 5'd9;
      6'd34, 6'd35:                   fid = 5'd10;
      6'd36:                          fid = 5'd11;
      6'd37:                          fid = 5'd12;
      6'd38:                          fid = 5'd13;
      6'd39:                          fid = 5'd14;
      6'd40, 6'd41:                   fid = 5'd15;
      6'd42, 6'd43:                   fid = 5'd16;
      6'd44:                          fid = 5'd17;
      6'd45:                          fid = 5'd18;
      default:                        fid = 5'd19;
    endcase
    return fid;
  endfunction

  // true on the byte that completes a record field
  function automatic logic rec_field_last(input logic [5:0] off);
    logic last;
    case (off)
      6'd3, 6'd7, 6'd11, 6'd13, 6'd15, 6'd19, 6'd23, 6'd27, 6'd31, 6'd33,
      6'd35, 6'd36, 6'd37, 6'd38, 6'd39, 6'd41, 6'd43, 6'd44, 6'd45, 6'd47:
        last = 1'b1;
      default:
        last = 1'b0;
    endcase
    return last;
  endfunction

endpackage

`default_nettype wire

// ===== src/nfv5_ifs.sv =====
// ----------------------------------------------------------------------------
// nfv5 channel interfaces
// Valid/ready channels for datagram bytes, parse results and configuration.
// ----------------------------------------------------------------------------
`default_nettype none

interface nfv5_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_datagram;

  modport source (output valid, data_byte, end_of_datagram, input ready);
  modport sink   (input valid, data_byte, end_of_datagram, output ready);
endinterface

interface nfv5_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [4:0]  record_index;
  logic [4:0]  field_id;
  logic [31:0] field_value;
  logic [1:0]  error_code;
  logic        last_result;

  modport source (output valid, kind, record_index, field_id, field_value, error_code,
                  last_result, input ready);
  modport sink   (input valid, kind, record_index, field_id, field_value, error_code,
                  last_result, output ready);
endinterface

interface nfv5_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] expected_version;

  modport source (output valid, expected_version, input ready);
  modport sink   (input valid, expected_version, output ready);
endinterface

`default_nettype wire

// ===== src/nfv5_result_queue.sv =====
// ----------------------------------------------------------------------------
// nfv5_result_queue
// Small result queue: takes up to two results per cycle, hands out one.
// ----------------------------------------------------------------------------
`default_nettype none

module nfv5_result_queue import nfv5_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic [1:0] push_cnt,
  input  result_t    push_a,
  input  result_t    push_b,
  output logic       room2,
  output logic       out_valid,
  input  logic       out_ready,
  output result_t    out_data
);

  localparam int unsigned PW = $clog2(DEPTH);

  result_t       mem [DEPTH];
  logic [PW-1:0] rd_ptr;
  logic [PW-1:0] wr_ptr;
  logic [PW:0]   count;
  logic          pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = count != '0;
  assign out_data  = mem[rd_ptr];
  assign room2     = count <= (PW+1)'(DEPTH - 2);

  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      mem[wr_ptr] <= push_a;
    end
    if (push_cnt == 2'd2) begin
      mem[wr_ptr + PW'(1)] <= push_b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PW'(push_cnt);
      if (pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      count <= count + (PW+1)'(push_cnt) - (PW+1)'(pop);
    end
  end

endmodule

`default_nettype wire

// ===== src/netflow_v5_datagram_parser.sv =====
// ordering: a field completed by a byte is written to the result queue when the byte
// is accepted; the end byte's verdict is queued right behind it when both come at once
// throughput: one byte per cycle; ready drops only while the four-entry result queue
// has fewer than two free entries, which happens only under output stall
// reset: synchronous, clears parse state and the queue, expected_version returns to 5
// ----------------------------------------------------------------------------
// netflow_v5_datagram_parser
// Byte-serial NetFlow v5 datagram parser: emits header and record fields and
// an accept or reject verdict on the final byte.
// ----------------------------------------------------------------------------
`default_nettype none

module netflow_v5_datagram_parser import nfv5_pkg::*; #(
  parameter int unsigned MAX_RECORDS = MAX_RECORDS_DEFAULT
) (
  input  logic            clk,
  input  logic            rst,
  nfv5_cfg_if.sink        cfg,
  nfv5_byte_if.sink       byte_in,
  nfv5_result_if.source   result_out
);

  localparam int unsigned CW = $clog2(MAX_RECORDS + 1);
  localparam int unsigned TW = $clog2(HDR_BYTES + REC_BYTES * MAX_RECORDS + 1);

  // parse state
  logic [15:0] expected_version;
  logic [15:0] byte_position, byte_position_next;
  logic [31:0] field_acc, field_acc_next;
  logic [15:0] declared_count, declared_count_next;
  logic [4:0]  current_record, current_record_next;
  logic [5:0]  offset_in_record, offset_in_record_next;
  err_t        parse_error, parse_error_next;

  logic        accept;
  logic        room2;
  logic [31:0] acc_shift;
  logic [4:0]  hdr_fid;
  logic [5:0]  rec_off;
  logic [4:0]  rec_fid;
  logic [TW-1:0] total_now;
  logic [TW-1:0] total_end;
  logic        in_header;
  logic        in_records;
  logic        fld_emit;
  result_t     fld_res;
  result_t     end_res;
  err_t        end_err;
  logic [1:0]  push_cnt;
  result_t     push_a;
  result_t     queue_out;

  // count*48 as two shifts; only counts within range matter when no error is latched
  function automatic logic [TW-1:0] total_len(input logic [15:0] cnt);
    logic [TW-1:0] c;
    c = TW'(cnt[CW-1:0]);
    return TW'(HDR_BYTES) + (c << 5) + (c << 4);
  endfunction

  assign accept    = byte_in.valid && byte_in.ready;
  assign acc_shift = {field_acc[23:0], byte_in.data_byte};
  assign in_header = byte_position < 16'(HDR_BYTES);
  assign total_now = total_len(declared_count);
  assign in_records = {1'b0, byte_position} < 17'(total_now);
  assign hdr_fid   = hdr_field(byte_position[4:0]);
  assign rec_off   = (offset_in_record >= 6'(REC_BYTES)) ? 6'd0 : offset_in_record;
  assign rec_fid   = rec_field(rec_off);

  always_comb begin
    byte_position_next    = byte_position;
    field_acc_next        = field_acc;
    declared_count_next   = declared_count;
    current_record_next   = current_record;
    offset_in_record_next = offset_in_record;
    parse_error_next      = parse_error;
    fld_emit              = 1'b0;
    fld_res               = '{kind: KIND_HDR, record_index: 5'd0, field_id: hdr_fid,
                              field_value: acc_shift, error_code: ERR_NONE,
                              last_result: !byte_in.end_of_datagram};

    if (parse_error == ERR_NONE) begin
      if (in_header) begin
        field_acc_next     = acc_shift;
        byte_position_next = byte_position + 16'd1;
        if (hdr_field_last(byte_position[4:0])) begin
          fld_emit       = 1'b1;
          field_acc_next = '0;
          if (hdr_fid == HDR_FID_VERSION && acc_shift != {16'd0, expected_version}) begin
            parse_error_next = ERR_VERSION;
          end
          if (hdr_fid == HDR_FID_COUNT) begin
            declared_count_next = acc_shift[15:0];
            if (acc_shift[15:0] == 16'd0 || acc_shift[15:0] > 16'(MAX_RECORDS)) begin
              parse_error_next = ERR_COUNT;
            end
          end
        end
      end else if (in_records) begin
        field_acc_next     = acc_shift;
        byte_position_next = byte_position + 16'd1;
        if (rec_field_last(rec_off)) begin
          fld_emit             = 1'b1;
          fld_res.kind         = KIND_REC;
          fld_res.record_index = current_record;
          fld_res.field_id     = rec_fid;
          field_acc_next       = '0;
        end
        if (rec_off == 6'(REC_BYTES - 1)) begin
          offset_in_record_next = 6'd0;
          current_record_next   = current_record + 5'd1;
        end else begin
          offset_in_record_next = rec_off + 6'd1;
        end
      end else if (byte_position != 16'hFFFF) begin
        // bytes past the expected length only advance the position
        byte_position_next = byte_position + 16'd1;
      end
    end

    // verdict on the end byte, judged on the updated state
    total_end = total_len(declared_count_next);
    end_err   = parse_error_next;
    if (parse_error_next == ERR_NONE &&
        ({1'b0, byte_position_next} < 17'(HDR_BYTES) ||
         {1'b0, byte_position_next} < 17'(total_end))) begin
      end_err = ERR_TRUNC;
    end
    if (end_err == ERR_NONE) begin
      end_res = '{kind: KIND_DONE, record_index: 5'd0, field_id: 5'd0,
                  field_value: {16'd0, declared_count_next}, error_code: ERR_NONE,
                  last_result: 1'b1};
    end else begin
      end_res = '{kind: KIND_REJECT, record_index: 5'd0, field_id: 5'd0,
                  field_value: 32'd0, error_code: end_err, last_result: 1'b1};
    end

    if (byte_in.end_of_datagram) begin
      byte_position_next    = '0;
      field_acc_next        = '0;
      declared_count_next   = '0;
      current_record_next   = '0;
      offset_in_record_next = '0;
      parse_error_next      = ERR_NONE;
    end
  end

  always_comb begin
    push_cnt = 2'd0;
    push_a   = fld_emit ? fld_res : end_res;
    if (accept) begin
      push_cnt = 2'(fld_emit) + 2'(byte_in.end_of_datagram);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_version <= VERSION_RESET;
      byte_position    <= '0;
      field_acc        <= '0;
      declared_count   <= '0;
      current_record   <= '0;
      offset_in_record <= '0;
      parse_error      <= ERR_NONE;
    end else begin
      if (cfg.valid && cfg.ready) begin
        expected_version <= cfg.expected_version;
      end
      if (accept) begin
        byte_position    <= byte_position_next;
        field_acc        <= field_acc_next;
        declared_count   <= declared_count_next;
        current_record   <= current_record_next;
        offset_in_record <= offset_in_record_next;
        parse_error      <= parse_error_next;
      end
    end
  end

  nfv5_result_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_result_queue (
    .clk       (clk),
    .rst       (rst),
    .push_cnt  (push_cnt),
    .push_a    (push_a),
    .push_b    (end_res),
    .room2     (room2),
    .out_valid (result_out.valid),
    .out_ready (result_out.ready),
    .out_data  (queue_out)
  );

  assign cfg.ready     = 1'b1;
  assign byte_in.ready = room2;

  assign result_out.kind         = queue_out.kind;
  assign result_out.record_index = queue_out.record_index;
  assign result_out.field_id     = queue_out.field_id;
  assign result_out.field_value  = queue_out.field_value;
  assign result_out.error_code   = queue_out.error_code;
  assign result_out.last_result  = queue_out.last_result;

endmodule

`default_nettype wire

// ===== src/nfv5_checker.sv =====
// ----------------------------------------------------------------------------
// nfv5_checker
// Port-level checks for the NetFlow v5 datagram parser, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module nfv5_checker import nfv5_pkg::*; (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        in_end,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [1:0]  out_kind,
  input wire logic [4:0]  out_record_index,
  input wire logic [4:0]  out_field_id,
  input wire logic [31:0] out_field_value,
  input wire logic [1:0]  out_error_code,
  input wire logic        out_last
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) &&
      $stable(out_record_index) && $stable(out_field_id) &&
      $stable(out_field_value) && $stable(out_error_code) && $stable(out_last))
    else $error("result changed while stalled");

  // an end byte always leaves a verdict waiting
  a_end_verdict: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_end |=> out_valid)
    else $error("no result after end byte");

  // reset empties the queue and opens the input
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("queue not empty after reset");

  // a verdict closes the results of its byte
  a_verdict_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_kind == KIND_DONE || out_kind == KIND_REJECT) |-> out_last)
    else $error("verdict not marked last");

endmodule

bind netflow_v5_datagram_parser nfv5_checker u_nfv5_checker (
  .clk              (clk),
  .rst              (rst),
  .in_valid         (byte_in.valid),
  .in_ready         (byte_in.ready),
  .in_end           (byte_in.end_of_datagram),
  .out_valid        (result_out.valid),
  .out_ready        (result_out.ready),
  .out_kind         (result_out.kind),
  .out_record_index (result_out.record_index),
  .out_field_id     (result_out.field_id),
  .out_field_value  (result_out.field_value),
  .out_error_code   (result_out.error_code),
  .out_last         (result_out.last_result)
);

`default_nettype wire
